// ===== rtl/mbwmc_pkg.sv =====
package mbwmc_pkg;

  // Reflected Modbus CRC-16 polynomial and its start value.
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  // Reset values of the configuration registers.
  localparam logic [15:0] COUNT_MIN_RESET = 16'd1;
  localparam logic [15:0] COUNT_MAX_RESET = 16'd123;

  // Register indexes on the configuration port.
  localparam logic CFG_COUNT_MIN = 1'b0;
  localparam logic CFG_COUNT_MAX = 1'b1;

  // Frame positions of the header fields.
  localparam logic [8:0] POS_SLAVE      = 9'd0;
  localparam logic [8:0] POS_FCODE      = 9'd1;
  localparam logic [8:0] POS_OFFSET_HI  = 9'd2;
  localparam logic [8:0] POS_OFFSET_LO  = 9'd3;
  localparam logic [8:0] POS_COUNT_HI   = 9'd4;
  localparam logic [8:0] POS_COUNT_LO   = 9'd5;
  localparam logic [8:0] POS_BYTECOUNT  = 9'd6;
  localparam logic [8:0] HEADER_LENGTH  = 9'd7;

  typedef enum logic [2:0] {
    STATUS_OK          = 3'd0,
    STATUS_CRC_ERROR   = 3'd1,
    STATUS_COUNT_ERROR = 3'd2,
    STATUS_BELOW_MIN   = 3'd3,
    STATUS_ABOVE_MAX   = 3'd4
  } status_t;

  // One result item as it travels through the output queue.
  typedef struct packed {
    status_t     status;
    logic [7:0]  slave_address;
    logic [7:0]  function_code;
    logic [15:0] start_offset;
    logic [15:0] register_count;
    logic [7:0]  byte_count;
  } result_t;

  // Occupancy flags of the output queue.
  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_flags_t;

  // One byte through the reflected CRC-16, one bit per step.
  function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
    logic [15:0] c;
    c = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// ===== rtl/mbwmc_out_queue.sv =====
module mbwmc_out_queue (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    push,
  input  mbwmc_pkg::result_t      push_data,
  input  logic                    pop,
  output mbwmc_pkg::result_t      head,
  output mbwmc_pkg::queue_flags_t flags
);
  import mbwmc_pkg::*;

  result_t     slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic [1:0]  count_next;

  // Occupancy follows pushes and pops.
  always_comb begin
    count_next = count;
    if (push && !pop) begin
      count_next = count + 2'd1;
    end else if (pop && !push) begin
      count_next = count - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count_next;
    end
  end

  // Result slots hold payload only.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  assign head            = slots[rd_ptr];
  assign flags.not_empty = (count != 2'd0);
  assign flags.full      = (count == 2'd2);

endmodule

// ===== rtl/modbus_write_multiple_checker.sv =====
// Channel  | Direction | Handshake            | Payload
// input    | in        | in_valid / in_stall  | rx_byte, frame_start
// result   | out       | out_valid / out_stall| status, slave_address, function_code,
//          |           |                      | start_offset, register_count, byte_count
// config   | in        | cfg_write            | cfg_index, cfg_data
//
// One byte is taken per cycle unless in_stall is high; its CRC update is fixed logic
// in that cycle. A result is ready in the cycle after the second CRC byte is taken.
// Results wait in a two-entry queue; in_stall rises only when both entries are full.
// Reset is synchronous and closes any open frame; limits return to 1 and 123.
module modbus_write_multiple_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  rx_byte,
  input  logic        frame_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  slave_address,
  output logic [7:0]  function_code,
  output logic [15:0] start_offset,
  output logic [15:0] register_count,
  output logic [7:0]  byte_count,
  input  logic        cfg_write,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);
  import mbwmc_pkg::*;

  logic [15:0]  count_min;
  logic [15:0]  count_max;

  logic [8:0]   byte_position;
  logic [8:0]   byte_position_next;
  logic         in_frame;
  logic         in_frame_next;
  logic [15:0]  crc_accum;
  logic [15:0]  crc_accum_next;
  logic [7:0]   rx_crc_low;
  logic [7:0]   rx_crc_low_next;
  logic [7:0]   held_slave;
  logic [7:0]   held_slave_next;
  logic [7:0]   held_fcode;
  logic [7:0]   held_fcode_next;
  logic [15:0]  held_offset;
  logic [15:0]  held_offset_next;
  logic [15:0]  held_count;
  logic [15:0]  held_count_next;
  logic [7:0]   held_bytecount;
  logic [7:0]   held_bytecount_next;

  logic         accept;
  logic         pos_valid;
  logic [8:0]   pos;
  logic [15:0]  crc_cur;
  logic [7:0]   bytecount_cur;
  logic [8:0]   data_end;
  logic [15:0]  rx_crc;
  logic         push;
  result_t      result;
  result_t      head;
  queue_flags_t flags;

  assign accept = in_valid && !in_stall;

  // A start byte opens a fresh frame; other bytes count only inside a frame.
  assign pos_valid     = accept && (frame_start || in_frame);
  assign pos           = frame_start ? POS_SLAVE : byte_position;
  assign crc_cur       = frame_start ? CRC_INIT : crc_accum;
  assign bytecount_cur = (pos == POS_BYTECOUNT) ? rx_byte : held_bytecount;
  assign data_end      = HEADER_LENGTH + {1'b0, bytecount_cur};
  assign rx_crc        = {rx_byte, rx_crc_low};

  // Frame tracking, header capture and CRC accumulation.
  always_comb begin
    byte_position_next  = byte_position;
    in_frame_next       = in_frame;
    crc_accum_next      = crc_accum;
    rx_crc_low_next     = rx_crc_low;
    held_slave_next     = held_slave;
    held_fcode_next     = held_fcode;
    held_offset_next    = held_offset;
    held_count_next     = held_count;
    held_bytecount_next = held_bytecount;
    push                = 1'b0;
    if (pos_valid) begin
      in_frame_next = 1'b1;
      unique case (pos)
        POS_SLAVE:     held_slave_next          = rx_byte;
        POS_FCODE:     held_fcode_next          = rx_byte;
        POS_OFFSET_HI: held_offset_next[15:8]   = rx_byte;
        POS_OFFSET_LO: held_offset_next[7:0]    = rx_byte;
        POS_COUNT_HI:  held_count_next[15:8]    = rx_byte;
        POS_COUNT_LO:  held_count_next[7:0]     = rx_byte;
        POS_BYTECOUNT: held_bytecount_next      = rx_byte;
        default: ;
      endcase
      if (pos < data_end) begin
        crc_accum_next     = crc16_byte(crc_cur, rx_byte);
        byte_position_next = pos + 9'd1;
      end else if (pos == data_end) begin
        crc_accum_next     = crc_cur;
        rx_crc_low_next    = rx_byte;
        byte_position_next = pos + 9'd1;
      end else begin
        in_frame_next      = 1'b0;
        byte_position_next = 9'd0;
        push               = 1'b1;
      end
    end
  end

  // Checks in priority order on the closing CRC byte.
  always_comb begin
    result.slave_address  = held_slave;
    result.function_code  = held_fcode;
    result.start_offset   = held_offset;
    result.register_count = held_count;
    result.byte_count     = held_bytecount;
    if (rx_crc != crc_accum) begin
      result.status = STATUS_CRC_ERROR;
    end else if (held_count != {9'd0, held_bytecount[7:1]}) begin
      result.status = STATUS_COUNT_ERROR;
    end else if (held_count < count_min) begin
      result.status = STATUS_BELOW_MIN;
    end else if (held_count > count_max) begin
      result.status = STATUS_ABOVE_MAX;
    end else begin
      result.status = STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position  <= 9'd0;
      in_frame       <= 1'b0;
      crc_accum      <= CRC_INIT;
      rx_crc_low     <= 8'd0;
      held_slave     <= 8'd0;
      held_fcode     <= 8'd0;
      held_offset    <= 16'd0;
      held_count     <= 16'd0;
      held_bytecount <= 8'd0;
    end else begin
      byte_position  <= byte_position_next;
      in_frame       <= in_frame_next;
      crc_accum      <= crc_accum_next;
      rx_crc_low     <= rx_crc_low_next;
      held_slave     <= held_slave_next;
      held_fcode     <= held_fcode_next;
      held_offset    <= held_offset_next;
      held_count     <= held_count_next;
      held_bytecount <= held_bytecount_next;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      count_min <= COUNT_MIN_RESET;
      count_max <= COUNT_MAX_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_COUNT_MIN: count_min <= cfg_data;
        CFG_COUNT_MAX: count_max <= cfg_data;
        default: ;
      endcase
    end
  end

  // Result queue decouples the two channels.
  mbwmc_out_queue u_out_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (result),
    .pop       (out_valid && !out_stall),
    .head      (head),
    .flags     (flags)
  );

  assign in_stall       = flags.full;
  assign out_valid      = flags.not_empty;
  assign status         = head.status;
  assign slave_address  = head.slave_address;
  assign function_code  = head.function_code;
  assign start_offset   = head.start_offset;
  assign register_count = head.register_count;
  assign byte_count     = head.byte_count;

endmodule

// ===== rtl/mbwmc_checker.sv =====
module mbwmc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic [7:0]  rx_byte,
  input logic        frame_start,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  status,
  input logic [7:0]  slave_address,
  input logic [7:0]  function_code,
  input logic [15:0] start_offset,
  input logic [15:0] register_count,
  input logic [7:0]  byte_count,
  input logic        cfg_write,
  input logic        cfg_index,
  input logic [15:0] cfg_data
);
  import mbwmc_pkg::*;

  // A stalled result holds its payload until the transfer.
  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status) && $stable(register_count)
      && $stable(byte_count) && $stable(start_offset))
    else $error("stalled result changed");

  // Input stalls only while results are waiting.
  a_stall_needs_result: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid)
    else $error("input stalled with no pending result");

  // A passing frame has a register count matching its byte count.
  a_ok_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_OK) |-> register_count == {9'd0, byte_count[7:1]})
    else $error("ok status with inconsistent count");

  // A count error is reported only when the counts really differ.
  a_count_error: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == STATUS_COUNT_ERROR)
      |-> register_count != {9'd0, byte_count[7:1]})
    else $error("count error reported on matching count");

endmodule

bind modbus_write_multiple_checker mbwmc_checker u_mbwmc_checker (.*);

// ===== tb/tb_top.sv =====
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import mbwmc_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int LONG_HOLD_CYCLES = 400;
  localparam int PHASE_ITEMS = 230;
  localparam int SETTLE_CYCLES = 4;

  // One received byte as it waits to be driven.
  typedef struct {
    logic [7:0] data;
    logic       first;
  } rx_item_t;

  // What the checker should report for one completed request.
  typedef struct {
    status_t     status;
    logic [7:0]  slave;
    logic [7:0]  fcode;
    logic [15:0] offset;
    logic [15:0] count;
    logic [7:0]  bytecount;
  } request_report_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  rx_byte = 8'h00;
  logic        frame_start = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [2:0]  status;
  logic [7:0]  slave_address;
  logic [7:0]  function_code;
  logic [15:0] start_offset;
  logic [15:0] register_count;
  logic [7:0]  byte_count;
  logic        cfg_write = 1'b0;
  logic        cfg_index = CFG_COUNT_MIN;
  logic [15:0] cfg_data = 16'h0000;

  rx_item_t        pending_bytes[$];
  request_report_t expected_reports[$];

  int error_count = 0;
  int cycle_count = 0;
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  int holds_wanted = 0;
  int holds_done = 0;
  int hold_left = 0;

  // Shadow copy of the limits and of the frame tracking state.
  logic [15:0] lim_min = COUNT_MIN_RESET;
  logic [15:0] lim_max = COUNT_MAX_RESET;
  logic        open_frame = 1'b0;
  logic [8:0]  frame_pos = 9'd0;
  logic [15:0] crc_run = CRC_INIT;
  logic [7:0]  crc_low_seen = 8'h00;
  logic [7:0]  cap_slave = 8'h00;
  logic [7:0]  cap_fcode = 8'h00;
  logic [15:0] cap_offset = 16'h0000;
  logic [15:0] cap_count = 16'h0000;
  logic [7:0]  cap_bytecount = 8'h00;

  modbus_write_multiple_checker u_top (.*);

  // Free-running clock.
  initial begin
    forever #5 clk = ~clk;
  end

  task automatic flag_error(input string msg);
    $display("mismatch: %s", msg);
    error_count++;
  endtask

  // Modbus CRC-16 over one byte, least significant bit first.
  function automatic logic [15:0] crc16_step(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] r;
    r = acc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  // Follows one accepted byte through the request and queues a report when
  // the second CRC byte closes the frame.
  function automatic void track_request_byte(input logic [7:0] b, input logic first);
    logic [8:0]      data_end;
    logic [15:0]     rx_crc;
    request_report_t rep;
    if (first) begin
      open_frame = 1'b1;
      frame_pos = 9'd0;
      crc_run = CRC_INIT;
    end else if (!open_frame) begin
      return;
    end
    data_end = HEADER_LENGTH + {1'b0, ((frame_pos == POS_BYTECOUNT) ? b : cap_bytecount)};
    case (frame_pos)
      POS_SLAVE:     cap_slave = b;
      POS_FCODE:     cap_fcode = b;
      POS_OFFSET_HI: cap_offset[15:8] = b;
      POS_OFFSET_LO: cap_offset[7:0] = b;
      POS_COUNT_HI:  cap_count[15:8] = b;
      POS_COUNT_LO:  cap_count[7:0] = b;
      POS_BYTECOUNT: cap_bytecount = b;
      default: ;
    endcase
    if (frame_pos < data_end) begin
      crc_run = crc16_step(crc_run, b);
      frame_pos = frame_pos + 9'd1;
    end else if (frame_pos == data_end) begin
      crc_low_seen = b;
      frame_pos = frame_pos + 9'd1;
    end else begin
      rx_crc = {b, crc_low_seen};
      if (rx_crc != crc_run) rep.status = STATUS_CRC_ERROR;
      else if (cap_count != {8'h00, 1'b0, cap_bytecount[7:1]}) rep.status = STATUS_COUNT_ERROR;
      else if (cap_count < lim_min) rep.status = STATUS_BELOW_MIN;
      else if (cap_count > lim_max) rep.status = STATUS_ABOVE_MAX;
      else rep.status = STATUS_OK;
      rep.slave = cap_slave;
      rep.fcode = cap_fcode;
      rep.offset = cap_offset;
      rep.count = cap_count;
      rep.bytecount = cap_bytecount;
      expected_reports.push_back(rep);
      open_frame = 1'b0;
      frame_pos = 9'd0;
    end
  endfunction

  // Builds one request with random data and queues its bytes. A cut_at above zero
  // and below the frame length keeps only that many bytes, leaving a partial frame.
  function automatic int add_request(input logic [7:0] slave, input logic [7:0] fcode,
                                     input logic [15:0] offset, input logic [15:0] count,
                                     input int data_len, input bit bad_crc, input int cut_at);
    logic [7:0]  frame[$];
    logic [15:0] crc;
    int          n;
    frame = {slave, fcode, offset[15:8], offset[7:0], count[15:8], count[7:0],
             8'(data_len)};
    for (int i = 0; i < data_len; i++) frame.push_back(8'($urandom));
    crc = CRC_INIT;
    foreach (frame[i]) crc = crc16_step(crc, frame[i]);
    if (bad_crc) crc = crc ^ 16'($urandom_range(65535, 1));
    frame.push_back(crc[7:0]);
    frame.push_back(crc[15:8]);
    n = (cut_at > 0 && cut_at < frame.size()) ? cut_at : frame.size();
    for (int i = 0; i < n; i++) pending_bytes.push_back('{frame[i], i == 0});
    return n;
  endfunction

  // Random request: mostly short and well formed, with some long ones,
  // wrong counts, corrupted CRCs and frames cut short.
  function automatic int add_random_request();
    int          len;
    int          pick;
    logic [15:0] cnt;
    bit          bad;
    int          cut;
    pick = $urandom_range(99);
    if (pick < 90) len = $urandom_range(20);
    else if (pick < 97) len = $urandom_range(80, 21);
    else len = $urandom_range(255, 240);
    pick = $urandom_range(99);
    if (pick < 70) cnt = 16'(len / 2);
    else if (pick < 80) cnt = 16'($urandom_range(65535));
    else if (pick < 90) cnt = {8'($urandom_range(255, 1)), 8'(len / 2)};
    else cnt = $urandom_range(1) ? 16'hFFFF : 16'h0000;
    bad = $urandom_range(99) < 12;
    cut = ($urandom_range(99) < 8) ? $urandom_range(len + 8, 1) : 0;
    return add_request(8'($urandom), 8'($urandom), 16'($urandom), cnt, len, bad, cut);
  endfunction

  task automatic write_limit(input logic idx, input logic [15:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    if (idx == CFG_COUNT_MIN) lim_min = value;
    else lim_max = value;
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  // Waits until every byte is sent and every report has come back.
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || in_valid || expected_reports.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Byte driver: feeds the next pending byte whenever the last one has
  // been transferred, with random gaps.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) track_request_byte(rx_byte, frame_start);
      if (!in_valid || !in_stall) begin
        if (pending_bytes.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
          in_valid <= 1'b1;
          rx_byte <= pending_bytes[0].data;
          frame_start <= pending_bytes[0].first;
          void'(pending_bytes.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result back-pressure, with a long hold whenever one is requested.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (holds_done < holds_wanted) begin
      out_stall <= 1'b1;
      hold_left <= LONG_HOLD_CYCLES;
      holds_done <= holds_done + 1;
    end else begin
      out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end
  end

  // Result monitor: each transfer is checked against the oldest report.
  always @(posedge clk) begin : result_monitor
    request_report_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_reports.size() == 0) begin
        flag_error("result transfer with no request outstanding");
      end else begin
        want = expected_reports.pop_front();
        if (status !== want.status)
          flag_error($sformatf("status got %0d expected %0d", status, want.status));
        if (slave_address !== want.slave)
          flag_error($sformatf("slave_address got %0h expected %0h", slave_address,
                               want.slave));
        if (function_code !== want.fcode)
          flag_error($sformatf("function_code got %0h expected %0h", function_code,
                               want.fcode));
        if (start_offset !== want.offset)
          flag_error($sformatf("start_offset got %0h expected %0h", start_offset,
                               want.offset));
        if (register_count !== want.count)
          flag_error($sformatf("register_count got %0h expected %0h", register_count,
                               want.count));
        if (byte_count !== want.bytecount)
          flag_error($sformatf("byte_count got %0h expected %0h", byte_count,
                               want.bytecount));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Test sequence: phases of limit settings and idling patterns.
  initial begin
    int          phase_idle[6];
    int          phase_stall[6];
    logic [15:0] phase_min[6];
    logic [15:0] phase_max[6];
    int          budget;
    phase_idle  = '{0, 0, 79, 0, 27, 27};
    phase_stall = '{0, 0, 0, 79, 27, 27};
    phase_min   = '{COUNT_MIN_RESET, 16'd0, 16'd10, 16'hFFFF, 16'd0, 16'd4};
    phase_max   = '{COUNT_MAX_RESET, 16'hFFFF, 16'd20, 16'd0, 16'd0, 16'd4};

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 6; p++) begin
      sender_idle_pct = phase_idle[p];
      receiver_stall_pct = phase_stall[p];
      if (p > 0) begin
        write_limit(CFG_COUNT_MIN, phase_min[p]);
        write_limit(CFG_COUNT_MAX, phase_max[p]);
      end
      budget = 0;
      if (p == 0) begin
        // Byte outside any frame, then an all-ones header that passes.
        pending_bytes.push_back('{8'hFF, 1'b0});
        budget += add_request(8'hFF, 8'hFF, 16'hFFFF, 16'd1, 2, 1'b0, 0);
        // A partial frame aborted by a new start, whose zero count is below the limit.
        budget += add_request(8'h00, 8'h00, 16'h0000, 16'd0, 0, 1'b0, 3);
        budget += add_request(8'h00, 8'h00, 16'h0000, 16'd0, 0, 1'b0, 0);
        // Trailing byte after a closed frame is ignored.
        pending_bytes.push_back('{8'h00, 1'b0});
        // Count with a nonzero high byte must not match the byte count.
        budget += add_request(8'h5A, 8'h10, 16'h1234, 16'h0101, 2, 1'b0, 0);
        budget += add_request(8'hA5, 8'h03, 16'h8000, 16'd0, 0, 1'b1, 0);
      end
      // The first free-running phase starts with a long receiver hold.
      if (p == 1) holds_wanted = holds_wanted + 1;
      while (budget < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          repeat ($urandom_range(3, 1)) pending_bytes.push_back('{8'($urandom), 1'b0});
        end
        budget += add_random_request();
      end
      wait_drained();
    end

    repeat (10) @(posedge clk);
    while (expected_reports.size() != 0) begin
      flag_error("report never delivered");
      void'(expected_reports.pop_front());
    end
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== modbus_write_multiple_checker.f =====
rtl/mbwmc_pkg.sv
rtl/mbwmc_out_queue.sv
rtl/modbus_write_multiple_checker.sv
rtl/mbwmc_checker.sv
tb/tb_top.sv
